### hw/rtl/fnvlp_pkg.sv
// ----------------------------------------------------------------------------
// fnvlp_pkg
// Shared types and constants of the FNV-1a linear-probing hash table.
// ----------------------------------------------------------------------------
package fnvlp_pkg;

    localparam int unsigned CAPACITY_DEFAULT  = 1024;
    localparam int unsigned KEY_BYTES_DEFAULT = 8;

    localparam logic [63:0] HASH_BASIS = 64'hcbf29ce484222325;
    localparam logic [63:0] HASH_PRIME = 64'h00000100000001b3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_FIND   = 1'b1;

    // Classified request handed from the hashing front end to the prober
    typedef struct packed {
        logic        op;
        logic [63:0] key;
        logic [3:0]  key_len;
        logic [31:0] value;
        logic [63:0] hash;
    } fnvlp_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_WAIT,
        ST_CHECK,
        ST_WRITE,
        ST_CLEAR,
        ST_DONE
    } probe_state_t;

    typedef enum logic [1:0] {
        HS_IDLE,
        HS_MUL,
        HS_OUT
    } hash_state_t;

endpackage

### hw/rtl/fnv1a_linear_probe_hash_map_core.sv
// ----------------------------------------------------------------------------
// fnv1a_linear_probe_hash_map_core
// Fixed-size key/value table: FNV-1a 64 hash, linear probing, insert/find.
// ----------------------------------------------------------------------------
// Usage: send one request per s_axis beat; op travels in s_tuser, tdata packs
// key[63:0], key_len[67:64], value[99:68]. Each request gives exactly one
// m_axis beat: tdata packs ok, inserted, found_value[33:2].
// The hash front end folds the key bytes in turn through a split multiply. It feeds
// a two-entry queue to the prober, which accepts in its idle state, visits
// each slot through read, wait and check states (one memory port, registered
// read), writes a new insert in a write state and holds the result in a
// done state. The front end can hash the next request while the prober
// walks, so sustained rate is set by the slower of the hash loop and the
// probe walk.
// After reset the prober clears every slot's hash, one slot per cycle
// (CAPACITY slots, 1024 by default); the prober takes no requests meanwhile.
// If m_tready stays low the result is held, the prober stops, and the queue
// and front end fill and then deassert s_tready.
// ----------------------------------------------------------------------------
module fnv1a_linear_probe_hash_map_core #(
    parameter int unsigned CAPACITY  = fnvlp_pkg::CAPACITY_DEFAULT,
    parameter int unsigned KEY_BYTES = fnvlp_pkg::KEY_BYTES_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // key[63:0], key_len[67:64], value[99:68], zero pad
    input  logic         s_tuser,   // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata    // ok[0], inserted[1], found_value[33:2], zero pad
);

    logic                  f_valid, f_ready, q_valid, q_ready;
    fnvlp_pkg::fnvlp_req_t f_req, q_req;
    logic [33:0]           res;

    fnvlp_front #(.KEY_BYTES(KEY_BYTES)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_op(s_tuser),
        .in_key(s_tdata[63:0]), .in_key_len(s_tdata[67:64]), .in_value(s_tdata[99:68]),
        .out_valid(f_valid), .out_ready(f_ready), .out_req(f_req)
    );

    fnvlp_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(f_valid), .in_ready(f_ready), .in_req(f_req),
        .out_valid(q_valid), .out_ready(q_ready), .out_req(q_req)
    );

    fnvlp_probe #(.CAPACITY(CAPACITY)) u_probe (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(q_valid), .in_ready(q_ready), .in_req(q_req),
        .res_valid(m_tvalid), .res_ready(m_tready), .res_data(res)
    );

    assign m_tdata = {6'd0, res};

endmodule

### hw/rtl/fnvlp_ram.sv
// ----------------------------------------------------------------------------
// fnvlp_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module fnvlp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wr_data,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write the addressed entry when enabled; always read it
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[addr] <= wr_data;
        end
        rd_data <= mem_reg[addr];
    end

endmodule

### hw/rtl/fnvlp_front.sv
// ----------------------------------------------------------------------------
// fnvlp_front
// Request front end: masks the key, computes FNV-1a one byte at a time, with
// the 64x41 multiply split into two registered steps on the 32-bit halves.
// ----------------------------------------------------------------------------
module fnvlp_front #(
    parameter int unsigned KEY_BYTES = fnvlp_pkg::KEY_BYTES_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   in_op,
    input  logic [63:0]            in_key,
    input  logic [3:0]             in_key_len,
    input  logic [31:0]            in_value,
    output logic                   out_valid,
    input  logic                   out_ready,
    output fnvlp_pkg::fnvlp_req_t  out_req
);

    localparam logic [3:0] KB = 4'(KEY_BYTES);

    fnvlp_pkg::hash_state_t state_reg, state_next;
    fnvlp_pkg::fnvlp_req_t  req_reg, req_next;
    logic [3:0]  idx_reg, idx_next;
    logic [63:0] x_reg, x_next;
    logic        ph_reg, ph_next;
    logic [63:0] acc_reg, acc_next;

    logic [3:0]  len_sat;
    logic [63:0] key_mask;
    logic [63:0] x_cur;
    logic [63:0] pp;

    always_comb begin
        len_sat  = (in_key_len > KB) ? KB : in_key_len;
        key_mask = (len_sat >= 4'd8) ? '1 : ((64'd1 << {len_sat[2:0], 3'b000}) - 64'd1);
        x_cur    = req_reg.hash ^ {56'd0, req_reg.key[{idx_reg[2:0], 3'b000} +: 8]};
    end

    // hash*prime = (h << 40) + lo*0x1b3 + (hi*0x1b3 << 32); high part in step two
    always_comb begin
        pp = (64'(x_reg[63:32]) * 64'h1b3) << 32;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fnvlp_pkg::HS_IDLE;
        end else begin
            state_reg <= state_next;
        end
        req_reg <= req_next;
        idx_reg <= idx_next;
        x_reg   <= x_next;
        ph_reg  <= ph_next;
        acc_reg <= acc_next;
    end

    // Sequence: accept, fold one byte per two multiply steps, hand over
    always_comb begin
        state_next = state_reg;
        req_next   = req_reg;
        idx_next   = idx_reg;
        x_next     = x_reg;
        ph_next    = ph_reg;
        acc_next   = acc_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        out_req    = req_reg;
        unique case (state_reg)
            fnvlp_pkg::HS_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    req_next.op      = in_op;
                    req_next.key     = in_key & key_mask;
                    req_next.key_len = len_sat;
                    req_next.value   = in_value;
                    req_next.hash    = fnvlp_pkg::HASH_BASIS;
                    idx_next         = '0;
                    ph_next          = 1'b0;
                    state_next       = fnvlp_pkg::HS_MUL;
                end
            end
            fnvlp_pkg::HS_MUL: begin
                if (idx_reg >= req_reg.key_len) begin
                    if (req_reg.hash == 64'd0) begin
                        req_next.hash = 64'd1;
                    end
                    state_next = fnvlp_pkg::HS_OUT;
                end else if (!ph_reg) begin
                    x_next   = x_cur;
                    ph_next  = 1'b1;
                    acc_next = (x_cur << 40) + (64'(x_cur[31:0]) * 64'h1b3);
                end else begin
                    ph_next       = 1'b0;
                    idx_next      = idx_reg + 4'd1;
                    req_next.hash = acc_reg + pp;
                end
            end
            fnvlp_pkg::HS_OUT: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    state_next = fnvlp_pkg::HS_IDLE;
                end
            end
            default: state_next = fnvlp_pkg::HS_IDLE;
        endcase
    end

endmodule

### hw/rtl/fnvlp_queue.sv
// ----------------------------------------------------------------------------
// fnvlp_queue
// Two-entry queue decoupling the hash front end from the prober.
// ----------------------------------------------------------------------------
module fnvlp_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  fnvlp_pkg::fnvlp_req_t in_req,
    output logic                  out_valid,
    input  logic                  out_ready,
    output fnvlp_pkg::fnvlp_req_t out_req
);

    fnvlp_pkg::fnvlp_req_t data_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_req   = data_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) begin
            data_reg[wr_ptr_reg] <= in_req;
        end
    end

endmodule

### hw/rtl/fnvlp_probe.sv
// ----------------------------------------------------------------------------
// fnvlp_probe
// Back end: clears the table after reset, then walks slots one at a time
// through read, wait and check states, compares, updates or inserts, and holds the result for output.
// ----------------------------------------------------------------------------
module fnvlp_probe #(
    parameter int unsigned CAPACITY = fnvlp_pkg::CAPACITY_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  fnvlp_pkg::fnvlp_req_t in_req,
    output logic                  res_valid,
    input  logic                  res_ready,
    output logic [33:0]           res_data
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] LIMIT = CW'(CAPACITY * 3 / 4);
    localparam logic [AW:0]   CAP_W = (AW + 1)'(CAPACITY);

    fnvlp_pkg::probe_state_t state_reg, state_next;
    fnvlp_pkg::fnvlp_req_t   req_reg, req_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [AW:0]   steps_reg, steps_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ok_reg, ok_next;
    logic          ins_reg, ins_next;
    logic [31:0]   fv_reg, fv_next;

    logic          wr_hash, wr_rest;
    logic [63:0]   wd_hash;
    logic [63:0]   rd_hash, rd_key;
    logic [3:0]    rd_len;
    logic [31:0]   rd_val;
    logic          wr_val;
    logic [31:0]   wd_val;

    fnvlp_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_hash (
        .aclk(aclk), .wr_en(wr_hash), .addr(addr_reg), .wr_data(wd_hash), .rd_data(rd_hash)
    );
    fnvlp_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_key (
        .aclk(aclk), .wr_en(wr_rest), .addr(addr_reg), .wr_data(req_reg.key), .rd_data(rd_key)
    );
    fnvlp_ram #(.WIDTH(4), .DEPTH(CAPACITY)) u_len (
        .aclk(aclk), .wr_en(wr_rest), .addr(addr_reg), .wr_data(req_reg.key_len),
        .rd_data(rd_len)
    );
    fnvlp_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_val (
        .aclk(aclk), .wr_en(wr_val), .addr(addr_reg), .wr_data(wd_val), .rd_data(rd_val)
    );

    assign res_data = {fv_reg, ins_reg, ok_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fnvlp_pkg::ST_CLEAR;
            addr_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            count_reg <= count_next;
        end
        req_reg   <= req_next;
        steps_reg <= steps_next;
        ok_reg    <= ok_next;
        ins_reg   <= ins_next;
        fv_reg    <= fv_next;
    end

    // Probe sequencer
    always_comb begin
        state_next = state_reg;
        req_next   = req_reg;
        addr_next  = addr_reg;
        steps_next = steps_reg;
        count_next = count_reg;
        ok_next    = ok_reg;
        ins_next   = ins_reg;
        fv_next    = fv_reg;
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        wr_hash    = 1'b0;
        wr_rest    = 1'b0;
        wr_val     = 1'b0;
        wd_hash    = req_reg.hash;
        wd_val     = req_reg.value;
        unique case (state_reg)
            fnvlp_pkg::ST_CLEAR: begin
                wr_hash = 1'b1;
                wd_hash = '0;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == AW'(CAPACITY - 1)) begin
                    state_next = fnvlp_pkg::ST_IDLE;
                end
            end
            fnvlp_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    req_next   = in_req;
                    addr_next  = in_req.hash[AW-1:0];
                    steps_next = '0;
                    state_next = fnvlp_pkg::ST_READ;
                end
            end
            fnvlp_pkg::ST_READ: state_next = fnvlp_pkg::ST_WAIT;
            fnvlp_pkg::ST_WAIT: state_next = fnvlp_pkg::ST_CHECK;
            fnvlp_pkg::ST_CHECK: begin
                ok_next  = 1'b0;
                ins_next = 1'b0;
                fv_next  = '0;
                if (rd_hash == '0 || steps_reg == CAP_W) begin
                    if (req_reg.op == fnvlp_pkg::OP_INSERT && rd_hash == '0
                        && count_reg < LIMIT) begin
                        state_next = fnvlp_pkg::ST_WRITE;
                    end else begin
                        state_next = fnvlp_pkg::ST_DONE;
                    end
                end else if (rd_hash == req_reg.hash && rd_len == req_reg.key_len
                             && rd_key == req_reg.key) begin
                    ok_next = 1'b1;
                    if (req_reg.op == fnvlp_pkg::OP_FIND) begin
                        fv_next = rd_val;
                    end else begin
                        wr_val = 1'b1;
                    end
                    state_next = fnvlp_pkg::ST_DONE;
                end else begin
                    addr_next  = addr_reg + 1'b1;
                    steps_next = steps_reg + 1'b1;
                    state_next = (steps_reg + 1'b1 == CAP_W) ? fnvlp_pkg::ST_DONE
                                                              : fnvlp_pkg::ST_READ;
                end
            end
            fnvlp_pkg::ST_WRITE: begin
                wr_hash    = 1'b1;
                wr_rest    = 1'b1;
                wr_val     = 1'b1;
                count_next = count_reg + 1'b1;
                ok_next    = 1'b1;
                ins_next   = 1'b1;
                state_next = fnvlp_pkg::ST_DONE;
            end
            fnvlp_pkg::ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = fnvlp_pkg::ST_IDLE;
                end
            end
            default: state_next = fnvlp_pkg::ST_IDLE;
        endcase
    end

endmodule

### bench/fnv1a_linear_probe_hash_map_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnv1a_linear_probe_hash_map_core_tb
// Self-checking bench for the hash table core. Requests are predicted
// against a behavioural copy of the table. The bench covers short, empty,
// saturated and padded keys, updates and misses, and random stalls on both
// streams.
// ----------------------------------------------------------------------------
module fnv1a_linear_probe_hash_map_core_tb;

    localparam int unsigned SLOTS      = 1024;
    localparam int unsigned FILL_LIMIT = SLOTS * 3 / 4;
    localparam int unsigned POOL_SIZE  = 48;
    localparam int unsigned CYCLE_CAP  = 1500000;

    typedef struct packed {
        logic        ok;
        logic        inserted;
        logic [31:0] found_value;
    } lookup_result_t;

    // Behavioural table and queue of expected lookup results
    class hash_map_scoreboard;
        logic [63:0]    slot_hash [SLOTS];
        logic [63:0]    slot_key  [SLOTS];
        logic [3:0]     slot_len  [SLOTS];
        logic [31:0]    slot_val  [SLOTS];
        int unsigned    entry_count;
        lookup_result_t pending [$];
        int unsigned    errors, checked, hits, adds, rejects;

        function new();
            foreach (slot_hash[i]) begin
                slot_hash[i] = '0;
                slot_key[i]  = '0;
                slot_len[i]  = '0;
                slot_val[i]  = '0;
            end
            entry_count = 0;
        endfunction

        function logic [63:0] fnv1a(logic [63:0] key, int unsigned len);
            logic [63:0] h;
            h = fnvlp_pkg::HASH_BASIS;
            for (int i = 0; i < len; i++) begin
                h = (h ^ {56'd0, key[8*i +: 8]}) * fnvlp_pkg::HASH_PRIME;
            end
            return (h == 64'd0) ? 64'd1 : h;
        endfunction

        // Note an accepted request: walk the table and queue its answer
        function void note_request(logic op, logic [63:0] key_in, logic [3:0] len_in,
                                   logic [31:0] val);
            int unsigned    len, idx;
            logic [63:0]    key, h;
            logic           hit;
            lookup_result_t r;
            len = (len_in > 8) ? 8 : len_in;
            key = key_in;
            if (len < 8)
                key = key & ((64'd1 << (8 * len)) - 64'd1);
            h   = fnv1a(key, len);
            idx = h[9:0];
            hit = 1'b0;
            for (int s = 0; s < SLOTS; s++) begin
                if (slot_hash[idx] == 64'd0)
                    break;
                if (slot_hash[idx] == h && slot_len[idx] == len && slot_key[idx] == key) begin
                    hit = 1'b1;
                    break;
                end
                idx = (idx + 1) % SLOTS;
            end
            r = '0;
            if (op == fnvlp_pkg::OP_FIND) begin
                if (hit) begin
                    r.ok          = 1'b1;
                    r.found_value = slot_val[idx];
                    hits++;
                end
            end else if (hit) begin
                slot_val[idx] = val;
                r.ok          = 1'b1;
            end else if (entry_count < FILL_LIMIT && slot_hash[idx] == 64'd0) begin
                slot_hash[idx] = h;
                slot_key[idx]  = key;
                slot_len[idx]  = 4'(len);
                slot_val[idx]  = val;
                entry_count++;
                r.ok       = 1'b1;
                r.inserted = 1'b1;
                adds++;
            end else begin
                rejects++;
            end
            pending.push_back(r);
        endfunction

        task report(string what, logic [39:0] got, logic [39:0] want);
            $display("mismatch on result %0d: %s got %0h expected %0h", checked, what, got, want);
            errors++;
        endtask

        // Compare one accepted result with the oldest expectation
        task check_result(logic [39:0] data);
            lookup_result_t want;
            if (pending.size() == 0) begin
                report("unexpected result", data, 40'd0);
                return;
            end
            want = pending.pop_front();
            if (data[0] !== want.ok)
                report("ok", 40'(data[0]), 40'(want.ok));
            if (data[1] !== want.inserted)
                report("inserted", 40'(data[1]), 40'(want.inserted));
            if (data[33:2] !== want.found_value)
                report("found_value", 40'(data[33:2]), 40'(want.found_value));
            checked++;
        endtask
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;

    hash_map_scoreboard board;
    logic [63:0]        pool_key [POOL_SIZE];
    logic [3:0]         pool_len [POOL_SIZE];
    bit                 steady;
    int unsigned        cycles;

    fnv1a_linear_probe_hash_map_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // Observe both streams and run the cycle limit
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                board.note_request(s_tuser, s_tdata[63:0], s_tdata[67:64], s_tdata[99:68]);
            if (m_tvalid && m_tready)
                board.check_result(m_tdata);
        end
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("run timed out after %0d cycles", cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Stall the result stream at random, with a chance of 19 in a hundred, except in the steady stretch
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 19);
    end

    // Present one request and hold it until accepted, then maybe idle
    task automatic send_request(logic op, logic [63:0] key, logic [3:0] len, logic [31:0] val);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'd0, val, len, key};
        do @(posedge aclk); while (!s_tready);
        if (!steady && $urandom_range(99) < 19) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    // Fill bytes beyond the length with junk that the block must drop
    function automatic logic [63:0] pad_junk(logic [63:0] key, logic [3:0] len);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        if (len >= 8)
            return key;
        return (key & ((64'd1 << (8 * len)) - 64'd1)) | (junk & ~((64'd1 << (8 * len)) - 64'd1));
    endfunction

    task automatic random_request(bit fresh);
        int unsigned p;
        logic [63:0] k;
        logic [3:0]  l;
        logic        op;
        p  = $urandom_range(POOL_SIZE - 1);
        op = ($urandom_range(99) < 55) ? fnvlp_pkg::OP_INSERT : fnvlp_pkg::OP_FIND;
        if (fresh) begin
            k = {$urandom, $urandom};
            l = 4'($urandom_range(15));
        end else begin
            k = pad_junk(pool_key[p], pool_len[p]);
            l = pool_len[p];
            if (l == 8 && $urandom_range(3) == 0)
                l = 4'($urandom_range(9, 15));
        end
        send_request(op, k, l, $urandom);
    endtask

    initial begin
        board    = new();
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = fnvlp_pkg::OP_INSERT;
        s_tdata  = '0;
        m_tready = 1'b0;
        steady   = 1'b0;
        cycles   = 0;
        foreach (pool_key[i]) begin
            pool_key[i] = {$urandom, $urandom};
            pool_len[i] = 4'($urandom_range(8));
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty key, full-width and saturated lengths, junk bytes
        send_request(fnvlp_pkg::OP_FIND,   64'd0, 4'd0, 32'd0);
        send_request(fnvlp_pkg::OP_INSERT, 64'hdead_beef_0000_0000, 4'd0, 32'h1234_5678);
        send_request(fnvlp_pkg::OP_FIND,   64'hffff_ffff_ffff_ffff, 4'd0, 32'hffff_ffff);
        send_request(fnvlp_pkg::OP_INSERT, '1, 4'd8, '1);
        send_request(fnvlp_pkg::OP_FIND,   '1, 4'd15, 32'd0);
        send_request(fnvlp_pkg::OP_INSERT, '1, 4'd9, 32'h0000_0001);
        send_request(fnvlp_pkg::OP_FIND,   '1, 4'd8, 32'd0);
        send_request(fnvlp_pkg::OP_INSERT, 64'd0, 4'd8, 32'd0);
        send_request(fnvlp_pkg::OP_FIND,   64'd0, 4'd8, 32'd7);
        send_request(fnvlp_pkg::OP_FIND,   64'd0, 4'd7, 32'd0);
        send_request(fnvlp_pkg::OP_INSERT, 64'h5a5a_5a5a_5a00_0061, 4'd3, 32'haaaa_5555);
        send_request(fnvlp_pkg::OP_FIND,   64'h0123_4567_8900_0061, 4'd3, 32'd0);
        send_request(fnvlp_pkg::OP_INSERT, 64'h0000_0000_0000_0061, 4'd1, 32'h8000_0000);
        send_request(fnvlp_pkg::OP_FIND,   64'hffff_ffff_ffff_ff61, 4'd1, 32'd0);
        send_request(fnvlp_pkg::OP_FIND,   64'h0000_0000_0000_0062, 4'd1, 32'd0);
        send_request(fnvlp_pkg::OP_INSERT, 64'h8000_0000_0000_0000, 4'd8, 32'h0000_0001);
        send_request(fnvlp_pkg::OP_FIND,   64'h8000_0000_0000_0000, 4'd8, 32'd0);

        // Random: mostly a reused key set, some fresh keys; a stall-free stretch
        for (int n = 0; n < 470; n++) begin
            steady = (n >= 150 && n < 250);
            random_request($urandom_range(99) < 30);
        end
        steady = 1'b0;

        // Even mix of fresh and reused keys to finish
        for (int n = 0; n < 60; n++)
            random_request($urandom_range(1));

        s_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);

        $display("checked %0d results: %0d new entries, %0d find hits, %0d inserts refused",
                 board.checked, board.adds, board.hits, board.rejects);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
